// ===== rtl/thermistor_adc_to_temperature_unit_defines.svh =====
// Assertion macros shared by the thermistor conversion RTL.
`ifndef THERMISTOR_ADC_TO_TEMPERATURE_UNIT_DEFINES_SVH
`define THERMISTOR_ADC_TO_TEMPERATURE_UNIT_DEFINES_SVH

// Checked on every clock edge outside reset.
`define TADC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define TADC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/tadc_pkg.sv =====
// Shared constants, types and helpers of the thermistor conversion pipeline.
package tadc_pkg;

	localparam int ADC_BITS = 10;
	localparam int RS_W = 20;
	localparam int OFF_W = 16;
	localparam int COEF_W = 32;
	localparam int CFG_W = 32;
	localparam int IDX_W = 3;
	localparam int T_W = 19;

	localparam int NUM_W = RS_W + ADC_BITS;
	localparam int E_W = $clog2(NUM_W);
	localparam int FRAC_BITS = 16;
	localparam int LOG_W = E_W + FRAC_BITS;
	localparam int MANT_W = 31;
	localparam int LOG_LAT = FRAC_BITS + 2;

	localparam int LN2_FRAC = 30;
	localparam logic [LN2_FRAC-1:0] LN2_Q30 = 30'd744261118;
	localparam int D_W = LOG_W + 1;
	localparam int L_W = D_W;
	localparam int L2_W = 2 * L_W - 18;
	localparam int L3_W = L2_W + 1 + L_W - 16;
	localparam int S_W = 50;
	localparam int POLY_LAT = 9;

	localparam int Q_W = S_W - 1;
	localparam int RECIP_SHIFT = 48;
	localparam int KELVIN_OFFSET_Q8 = 69926;

	localparam logic [RS_W-1:0] SERIES_RESET = 20'd19750;
	localparam logic [OFF_W-1:0] OFFSET_RESET = 16'd10240;
	localparam logic [COEF_W-1:0] COEF_A_RESET = 32'd1109681585;
	localparam logic [COEF_W-1:0] COEF_B_RESET = 32'd261508444;
	localparam logic [COEF_W-1:0] COEF_C_RESET = 32'd222014;

	typedef enum logic [IDX_W-1:0] {
		REG_SERIES = 3'd0,
		REG_OFFSET = 3'd1,
		REG_COEF_A = 3'd2,
		REG_COEF_B = 3'd3,
		REG_COEF_C = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_ZERO = 2'd1,
		ST_SAT  = 2'd2
	} status_t;

	typedef struct packed {
		logic vld;
		logic zero;
	} tag_t;

	function automatic logic [E_W-1:0] lead_one(input logic [NUM_W-1:0] x);
		logic [E_W-1:0] pos;
		pos = '0;
		for (int i = 0; i < NUM_W; i++) begin
			if (x[i]) begin
				pos = E_W'(i);
			end
		end
		return pos;
	endfunction

endpackage

// ===== rtl/thermistor_adc_to_temperature_unit.sv =====
// Thermistor ADC code to Celsius conversion, top level.
// The pipeline has 79 register stages, from the input register through the log2,
// polynomial and reciprocal units; a result word leaves at an edge with out_ready high.
// Throughput is one word per cycle; the 49-stage reciprocal divider sets the depth.
// The whole pipeline stalls while a result word waits on out_ready.
// Asynchronous reset empties the pipeline and loads the register reset values.
`include "thermistor_adc_to_temperature_unit_defines.svh"

module thermistor_adc_to_temperature_unit
	import tadc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [ADC_BITS-1:0] adc_code,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [T_W-1:0]      temperature,
	output logic [1:0]          status,
	input  logic                cfg_we,
	input  logic [IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]    cfg_data
);

	logic en;
	logic [RS_W-1:0] series_q;
	logic signed [OFF_W-1:0] offset_q;
	logic [COEF_W-1:0] coef_a_q;
	logic [COEF_W-1:0] coef_b_q;
	logic [COEF_W-1:0] coef_c_q;

	tag_t tag_s1;
	logic [NUM_W-1:0] num_s1;
	logic [ADC_BITS-1:0] code_s1;
	logic [ADC_BITS-1:0] code_nz;
	logic [RS_W-1:0] rs_eff;
	logic [ADC_BITS-1:0] span;

	tag_t log_tag;
	logic [LOG_W-1:0] log_num;
	logic [LOG_W-1:0] log_code;
	tag_t poly_tag;
	logic signed [S_W-1:0] sum;
	status_t status_w;

	assign en = !out_valid || out_ready;
	assign in_ready = en;
	assign status = status_w;

	// A zero code takes the path of code one; its result is replaced at the end.
	assign code_nz = (adc_code == '0) ? ADC_BITS'(1) : adc_code;
	assign rs_eff = (series_q == '0) ? RS_W'(1) : series_q;
	assign span = ADC_BITS'((ADC_BITS + 1)'(1 << ADC_BITS) - (ADC_BITS + 1)'(code_nz));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			series_q <= SERIES_RESET;
			offset_q <= OFFSET_RESET;
			coef_a_q <= COEF_A_RESET;
			coef_b_q <= COEF_B_RESET;
			coef_c_q <= COEF_C_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SERIES: series_q <= cfg_data[RS_W-1:0];
				REG_OFFSET: offset_q <= cfg_data[OFF_W-1:0];
				REG_COEF_A: coef_a_q <= cfg_data[COEF_W-1:0];
				REG_COEF_B: coef_b_q <= cfg_data[COEF_W-1:0];
				REG_COEF_C: coef_c_q <= cfg_data[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (en) begin
			tag_s1.vld <= in_valid;
			tag_s1.zero <= (adc_code == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1 <= NUM_W'(rs_eff) * NUM_W'(span);
			code_s1 <= code_nz;
		end
	end

	tadc_log2 u_log2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_tag   (tag_s1),
		.num      (num_s1),
		.code     (NUM_W'(code_s1)),
		.out_tag  (log_tag),
		.log_num  (log_num),
		.log_code (log_code)
	);

	tadc_poly u_poly (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_tag   (log_tag),
		.log_num  (log_num),
		.log_code (log_code),
		.coef_a   (coef_a_q),
		.coef_b   (coef_b_q),
		.coef_c   (coef_c_q),
		.out_tag  (poly_tag),
		.sum      (sum)
	);

	tadc_recip u_recip (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_tag      (poly_tag),
		.sum         (sum),
		.cal_offset  (offset_q),
		.out_vld     (out_valid),
		.temperature (temperature),
		.status      (status_w)
	);

	`TADC_ASSERT(a_zero_code_temp, out_valid && status == ST_ZERO |-> temperature == '0,
		"zero code word must carry zero temperature")
	`TADC_ASSERT(a_status_code,
		out_valid |-> status == ST_OK || status == ST_ZERO || status == ST_SAT,
		"result word carries an unused status code")
	`TADC_ASSERT(a_stall_cause, !in_ready |-> out_valid && !out_ready,
		"input stalled without a waiting result word")
	`TADC_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> !out_valid,
		"result word shown during reset")

endmodule

// ===== rtl/tadc_log2.sv =====
// Two-lane pipelined base-2 logarithm in Q16 by repeated mantissa squaring.
module tadc_log2
	import tadc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  tag_t             in_tag,
	input  logic [NUM_W-1:0] num,
	input  logic [NUM_W-1:0] code,
	output tag_t             out_tag,
	output logic [LOG_W-1:0] log_num,
	output logic [LOG_W-1:0] log_code
);

	localparam int LANES = 2;
	localparam int SH_W = NUM_W + MANT_W - 1;
	localparam int SQ_W = 2 * MANT_W;

	tag_t tag_s [LOG_LAT];
	logic [NUM_W-1:0] x_in [LANES];
	logic [LOG_W-1:0] log_out [LANES];

	assign x_in[0] = num;
	assign x_in[1] = code;
	assign log_num = log_out[0];
	assign log_code = log_out[1];
	assign out_tag = tag_s[LOG_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LOG_LAT; i++) begin
				tag_s[i] <= '0;
			end
		end else if (en) begin
			tag_s[0] <= in_tag;
			for (int i = 1; i < LOG_LAT; i++) begin
				tag_s[i] <= tag_s[i-1];
			end
		end
	end

	for (genvar ln = 0; ln < LANES; ln++) begin : g_lane
		logic [NUM_W-1:0] x_s1;
		logic [E_W-1:0] e_s1;
		logic [SH_W-1:0] shifted;
		logic [MANT_W-1:0] mant_s [FRAC_BITS+1];
		logic [FRAC_BITS-1:0] frac_s [FRAC_BITS+1];
		logic [E_W-1:0] e_s [FRAC_BITS+1];
		logic [SQ_W-1:0] sq [FRAC_BITS];

		assign shifted = {x_s1, {(MANT_W-1){1'b0}}} >> e_s1;

		always_comb begin
			for (int r = 0; r < FRAC_BITS; r++) begin
				sq[r] = SQ_W'(mant_s[r]) * SQ_W'(mant_s[r]);
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s1 <= x_in[ln];
				e_s1 <= lead_one(x_in[ln]);
				mant_s[0] <= shifted[MANT_W-1:0];
				frac_s[0] <= '0;
				e_s[0] <= e_s1;
				for (int r = 0; r < FRAC_BITS; r++) begin
					mant_s[r+1] <= sq[r][SQ_W-1] ? sq[r][SQ_W-1:MANT_W]
						: sq[r][SQ_W-2:MANT_W-1];
					frac_s[r+1] <= {frac_s[r][FRAC_BITS-2:0], sq[r][SQ_W-1]};
					e_s[r+1] <= e_s[r];
				end
			end
		end

		assign log_out[ln] = {e_s[FRAC_BITS], frac_s[FRAC_BITS]};
	end

endmodule

// ===== rtl/tadc_poly.sv =====
// Pipelined natural log scaling and Steinhart-Hart polynomial sum in Q40.
module tadc_poly
	import tadc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  tag_t                    in_tag,
	input  logic [LOG_W-1:0]        log_num,
	input  logic [LOG_W-1:0]        log_code,
	input  logic [COEF_W-1:0]       coef_a,
	input  logic [COEF_W-1:0]       coef_b,
	input  logic [COEF_W-1:0]       coef_c,
	output tag_t                    out_tag,
	output logic signed [S_W-1:0]   sum
);

	localparam int P_W = D_W + LN2_FRAC + 1;
	localparam int SQ_W = 2 * L_W;
	localparam int L3P_W = L2_W + 1 + L_W;
	localparam int BP_W = COEF_W + 1 + L_W;
	localparam int CP_W = COEF_W + 1 + L3_W;

	tag_t tag_s [POLY_LAT];

	logic signed [D_W-1:0] d_s1;
	logic signed [P_W-1:0] p_s2;
	logic signed [L_W-1:0] l_s3;
	logic signed [SQ_W-1:0] sq_s4;
	logic signed [L_W-1:0] l_s4;
	logic signed [L3P_W-1:0] l3p_s5;
	logic signed [BP_W-1:0] bp_s5;
	logic signed [L3_W-1:0] l3_s6;
	logic signed [S_W-1:0] bt_s6;
	logic signed [CP_W-1:0] cp_s7;
	logic signed [S_W-1:0] bt_s7;
	logic signed [S_W-1:0] ct_s8;
	logic signed [S_W-1:0] bt_s8;
	logic signed [S_W-1:0] s_s9;

	logic signed [P_W-1:0] p_adj;
	logic signed [L3P_W-1:0] l3p_adj;
	logic signed [BP_W-1:0] bp_adj;
	logic signed [CP_W-1:0] cp_adj;
	logic [L2_W-1:0] l2;

	// Quotients by powers of two round toward zero.
	assign p_adj = p_s2 + $signed(P_W'({LN2_FRAC{p_s2[P_W-1]}}));
	assign l3p_adj = l3p_s5 + $signed(L3P_W'({FRAC_BITS{l3p_s5[L3P_W-1]}}));
	assign bp_adj = bp_s5 + $signed(BP_W'({FRAC_BITS{bp_s5[BP_W-1]}}));
	assign cp_adj = cp_s7 + $signed(CP_W'({FRAC_BITS{cp_s7[CP_W-1]}}));
	assign l2 = sq_s4[SQ_W-3:FRAC_BITS];

	assign out_tag = tag_s[POLY_LAT-1];
	assign sum = s_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < POLY_LAT; i++) begin
				tag_s[i] <= '0;
			end
		end else if (en) begin
			tag_s[0] <= in_tag;
			for (int i = 1; i < POLY_LAT; i++) begin
				tag_s[i] <= tag_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= $signed({1'b0, log_num}) - $signed({1'b0, log_code});
			p_s2 <= P_W'(d_s1) * $signed(P_W'({1'b0, LN2_Q30}));
			l_s3 <= L_W'(p_adj[P_W-1:LN2_FRAC]);
			sq_s4 <= SQ_W'(l_s3) * SQ_W'(l_s3);
			l_s4 <= l_s3;
			l3p_s5 <= $signed(L3P_W'({1'b0, l2})) * L3P_W'(l_s4);
			bp_s5 <= $signed(BP_W'({1'b0, coef_b})) * BP_W'(l_s4);
			l3_s6 <= l3p_adj[L3P_W-1:FRAC_BITS];
			bt_s6 <= S_W'($signed(bp_adj[BP_W-1:FRAC_BITS]));
			cp_s7 <= $signed(CP_W'({1'b0, coef_c})) * CP_W'(l3_s6);
			bt_s7 <= bt_s6;
			ct_s8 <= S_W'($signed(cp_adj[CP_W-1:FRAC_BITS]));
			bt_s8 <= bt_s7;
			s_s9 <= $signed(S_W'({1'b0, coef_a})) + bt_s8 + ct_s8;
		end
	end

endmodule

// ===== rtl/tadc_recip.sv =====
// Pipelined rounded reciprocal, Celsius and calibration offsets, zero code and saturation.
module tadc_recip
	import tadc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  tag_t                    in_tag,
	input  logic signed [S_W-1:0]   sum,
	input  logic signed [OFF_W-1:0] cal_offset,
	output logic                    out_vld,
	output logic [T_W-1:0]          temperature,
	output status_t                 status
);

	localparam int DV_W = S_W - 1;
	localparam int TF_W = S_W + 2;
	localparam int RC_LAT = Q_W + 1;
	localparam logic [Q_W-1:0] RECIP_NUM = Q_W'(1) << RECIP_SHIFT;
	localparam logic signed [TF_W-1:0] KELV_Q8 = TF_W'(KELVIN_OFFSET_Q8);
	localparam logic signed [TF_W-1:0] T_HI = TF_W'((1 << (T_W - 1)) - 1);
	localparam logic signed [TF_W-1:0] T_LO = -TF_W'(1 << (T_W - 1));

	tag_t tag_s [RC_LAT];
	logic [DV_W-1:0] rem_s [RC_LAT];
	logic [Q_W-1:0] n_s [RC_LAT];
	logic [DV_W-1:0] dv_s [RC_LAT];
	logic [Q_W-1:0] q_s [RC_LAT];
	logic pos_s [RC_LAT];
	logic [DV_W:0] trial [Q_W];
	logic ge [Q_W];

	logic pos_in;
	logic [DV_W-1:0] dv_in;
	logic signed [TF_W-1:0] t_full;

	assign pos_in = !sum[S_W-1] && (sum != '0);
	assign dv_in = pos_in ? sum[DV_W-1:0] : DV_W'(1);
	assign t_full = TF_W'($signed({1'b0, q_s[RC_LAT-1]})) - KELV_Q8 + TF_W'(cal_offset);

	always_comb begin
		for (int i = 0; i < Q_W; i++) begin
			trial[i] = {rem_s[i], n_s[i][Q_W-1]};
			ge[i] = trial[i] >= {1'b0, dv_s[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RC_LAT; i++) begin
				tag_s[i] <= '0;
			end
			out_vld <= 1'b0;
		end else if (en) begin
			tag_s[0] <= in_tag;
			for (int i = 1; i < RC_LAT; i++) begin
				tag_s[i] <= tag_s[i-1];
			end
			out_vld <= tag_s[RC_LAT-1].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= '0;
			dv_s[0] <= dv_in;
			n_s[0] <= RECIP_NUM + Q_W'(dv_in >> 1);
			q_s[0] <= '0;
			pos_s[0] <= pos_in;
			for (int i = 0; i < Q_W; i++) begin
				rem_s[i+1] <= ge[i] ? DV_W'(trial[i] - {1'b0, dv_s[i]})
					: DV_W'(trial[i]);
				n_s[i+1] <= {n_s[i][Q_W-2:0], 1'b0};
				dv_s[i+1] <= dv_s[i];
				q_s[i+1] <= {q_s[i][Q_W-2:0], ge[i]};
				pos_s[i+1] <= pos_s[i];
			end
			if (tag_s[RC_LAT-1].zero) begin
				temperature <= '0;
				status <= ST_ZERO;
			end else if (!pos_s[RC_LAT-1] || t_full > T_HI) begin
				temperature <= T_HI[T_W-1:0];
				status <= ST_SAT;
			end else if (t_full < T_LO) begin
				temperature <= T_LO[T_W-1:0];
				status <= ST_SAT;
			end else begin
				temperature <= t_full[T_W-1:0];
				status <= ST_OK;
			end
		end
	end

endmodule
